### design/sha256_message_hasher_unit_assert.svh
// Assertion macros shared by the hasher modules.
`ifndef SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_UNIT_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define SHU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A next-cycle implication checked outside reset.
`define SHU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sha256u_pkg.sv
package sha256u_pkg;

  typedef logic [31:0] word_t;

  // One transaction from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha256u_front.sv
// Input side: drops empty items and holds the rest in a small queue.
module sha256u_front #(
  parameter int QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_byte_present,
  input  logic                in_end_of_message,
  output logic                q_valid,
  input  logic                q_ready,
  output sha256u_pkg::item_t  q_item
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  sha256u_pkg::item_t mem_r [QDEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop, useful;

  assign useful   = in_byte_present | in_end_of_message;
  assign in_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign push     = in_valid & in_ready & useful;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid & q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{in_data_byte, in_byte_present, in_end_of_message};
    end
  end

  `include "sha256_message_hasher_unit_assert.svh"

  `SHU_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= (AW+1)'(QDEPTH), "queue overfilled")
  `SHU_ASSERT_NEXT(a_push_only, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + (AW+1)'(1), "queue count slip")
  `SHU_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - (AW+1)'(1), "queue count slip")

endmodule

### design/sha256u_back.sv
// Back part: packs bytes, pads, runs one round per cycle and emits the digest.
module sha256u_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  sha256u_pkg::item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  sha256u_pkg::word_t blk_r [16];
  sha256u_pkg::word_t w_r [16];
  sha256u_pkg::word_t v_r [8];
  sha256u_pkg::word_t h_r [8];
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  logic        fin_r;     // the running compression ends the message
  logic        padded_r;  // the pad byte has been placed
  logic [2:0]  oidx_r;
  // A full block caused by a byte that also ends the message resumes in padding.
  logic        pend_end_r;

  sha256u_pkg::word_t wcur, w15, w2, w7, s0, s1, t1, t2, e0, e1, ch, maj;
  logic [3:0] slot;

  assign slot = rnd_r[3:0];
  assign w15  = w_r[slot + 4'd1];
  assign w2   = w_r[slot + 4'd14];
  assign w7   = w_r[slot + 4'd9];
  assign s0   = sha256u_pkg::rotr(w15, 7) ^ sha256u_pkg::rotr(w15, 18) ^ (w15 >> 3);
  assign s1   = sha256u_pkg::rotr(w2, 17) ^ sha256u_pkg::rotr(w2, 19) ^ (w2 >> 10);
  assign wcur = rnd_r[6:4] == 3'd0 ? w_r[slot] : w_r[slot] + s0 + w7 + s1;
  assign e1   = sha256u_pkg::rotr(v_r[4], 6) ^ sha256u_pkg::rotr(v_r[4], 11)
              ^ sha256u_pkg::rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + e1 + ch + sha256u_pkg::ROUND_CONST[rnd_r[5:0]] + wcur;
  assign e0   = sha256u_pkg::rotr(v_r[0], 2) ^ sha256u_pkg::rotr(v_r[0], 13)
              ^ sha256u_pkg::rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = e0 + maj;

  assign q_ready         = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  function automatic sha256u_pkg::word_t put(input sha256u_pkg::word_t w,
                                             input logic [1:0] bp,
                                             input logic [7:0] b);
    sha256u_pkg::word_t r;
    r = w;
    r[(5'd3 - {3'd0, bp}) * 5'd8 +: 8] = b;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.byte_present && pos_r == 6'd63) begin
            state_nxt = ST_COMP;
          end else if (q_item.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD:  state_nxt = ST_COMP;
      ST_COMP: state_nxt = (rnd_r == 7'd63) ? ST_ADD : ST_COMP;
      ST_ADD: begin
        if (fin_r) begin
          state_nxt = ST_OUT;
        end else if (padded_r || pend_end_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT:  state_nxt = (out_ready && oidx_r == 3'd7) ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      len_r      <= '0;
      rnd_r      <= '0;
      fin_r      <= 1'b0;
      padded_r   <= 1'b0;
      pend_end_r <= 1'b0;
      oidx_r     <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha256u_pkg::INIT_HASH[i];
        v_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.byte_present) begin
              blk_r[pos_r[5:2]] <= put(blk_r[pos_r[5:2]], pos_r[1:0], q_item.data_byte);
              len_r <= len_r + 64'd8;
              pos_r <= pos_r + 6'd1;
            end
            if (q_item.byte_present && pos_r == 6'd63) begin
              pend_end_r <= q_item.end_of_message;
              fin_r      <= 1'b0;
              padded_r   <= 1'b0;
              rnd_r      <= '0;
              for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
              for (int i = 0; i < 16; i++) begin
                w_r[i] <= (i == 15) ? put(blk_r[15], 2'd3, q_item.data_byte) : blk_r[i];
              end
            end else if (q_item.end_of_message) begin
              pend_end_r <= 1'b0;
              padded_r   <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          // Lay out the whole padded block word by word in one step.
          for (int i = 0; i < 16; i++) begin
            sha256u_pkg::word_t nw;
            nw = blk_r[i];
            for (int b = 0; b < 4; b++) begin
              if (!padded_r && 6'(i * 4 + b) == pos_r) begin
                nw[(3 - b) * 8 +: 8] = sha256u_pkg::PAD_BYTE;
              end else if (padded_r || 6'(i * 4 + b) > pos_r) begin
                nw[(3 - b) * 8 +: 8] = 8'h00;
              end
            end
            if (i == 14 && (padded_r || pos_r < sha256u_pkg::LEN_POS)) nw = len_r[63:32];
            if (i == 15 && (padded_r || pos_r < sha256u_pkg::LEN_POS)) nw = len_r[31:0];
            w_r[i] <= nw;
          end
          fin_r    <= padded_r || pos_r < sha256u_pkg::LEN_POS;
          padded_r <= 1'b1;
          rnd_r    <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        ST_COMP: begin
          w_r[slot] <= wcur;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          oidx_r <= '0;
          if (!fin_r && pend_end_r) begin
            padded_r   <= 1'b0;
            pend_end_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha256u_pkg::INIT_HASH[i];
              pos_r    <= '0;
              len_r    <= '0;
              fin_r    <= 1'b0;
              padded_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `include "sha256_message_hasher_unit_assert.svh"

  `SHU_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
  `SHU_ASSERT_IMP(a_rnd, clk, rst_n, state_r == ST_COMP, rnd_r < 7'd64, "round counter past 63")
  `SHU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(oidx_r), "result dropped")

endmodule

### design/sha256_message_hasher_unit.sv
// SHA-256 streaming hasher. Message bytes arrive one per transaction; an item
// with end_of_message set pads the message and yields eight digest words, word 0
// first. A byte that fills a block loads the schedule, then runs its 64 rounds on
// the single round unit and one chain add; the end of a message runs one padded
// block, or two when the length field does not fit behind the pad byte, and then
// the eight output transactions.
// A QDEPTH-entry queue (2 by default) takes items while the round unit works.
module sha256_message_hasher_unit #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic               q_valid, q_ready;
  sha256u_pkg::item_t q_item;

  sha256u_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_byte_present,
    .in_end_of_message, .q_valid, .q_ready, .q_item
  );

  sha256u_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item, .out_valid, .out_ready,
    .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

### test/tb_sha256_message_hasher_unit.sv
`timescale 1ns / 1ps

module tb_sha256_message_hasher_unit;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // Streaming digest predictor and queue of expected digest words.
  class digest_scoreboard;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned fill;
    logic [63:0] bit_len;
    digest_out_t pending [$];
    int mismatches;

    function void clear_chain();
      for (int i = 0; i < 8; i++) chain[i] = sha256u_pkg::INIT_HASH[i];
      fill = 0;
      bit_len = '0;
    endfunction

    function void put(int unsigned pos, logic [7:0] b);
      blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int r = 0; r < 64; r++) begin
        if (r < 16) w[r] = blk[r];
        else w[r] = w[r-16] + w[r-7]
          + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3))
          + (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10));
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
          + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256u_pkg::ROUND_CONST[r] + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
          + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_input(logic [7:0] b, logic present, logic eom);
      digest_out_t d;
      if (present) begin
        put(fill, b);
        bit_len += 64'd8;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
      end
      if (!eom) return;
      put(fill, sha256u_pkg::PAD_BYTE);
      fill++;
      if (fill > 56) begin
        while (fill < 64) put(fill++, 8'h00);
        compress();
        fill = 0;
      end
      while (fill < 56) put(fill++, 8'h00);
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = chain[i];
        d.word_index = i[2:0];
        d.last_word = (i == 7);
        pending = {pending, d};
      end
      clear_chain();
    endfunction

    function void check_output(logic [31:0] dw, logic [2:0] wi, logic lw);
      digest_out_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected digest word %h", dw);
        return;
      end
      e = pending.pop_front();
      if (e.digest_word !== dw || e.word_index !== wi || e.last_word !== lw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                   e.digest_word, e.word_index, e.last_word, dw, wi, lw);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb;
  bit  quiet_phase;
  bit  long_hold_req;
  longint cycles;

  sha256_message_hasher_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check at the edge where the transaction happens.
  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_output(out_digest_word, out_word_index, out_last_word);

  // Receiver: random stall bursts, and one long hold on request.
  initial begin
    int n;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        long_hold_req = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic present, logic eom);
    int n;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_byte_present <= present;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, present, eom);
  endtask

  task automatic send_message(int len, bit eom_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, eom_with_byte && i == len - 1);
    if (!eom_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    bit eom_b;
    sb = new();
    sb.clear_chain();
    cycles = 0;
    quiet_phase = 0;
    long_hold_req = 0;
    in_valid = 0;
    in_data_byte = 0;
    in_byte_present = 0;
    in_end_of_message = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty message, extreme bytes, idle items.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();

    // Long receiver hold while the sender keeps offering bytes.
    long_hold_req = 1;
    send_message(3, 1);
    send_message(2, 0);
    send_message(55, 1);
    drain();
    sent = 61 + 7;

    send_message(56, 0);
    send_message(64, 1);
    sent += 121;
    while (sent < 450) begin
      if (sent > 380) quiet_phase = 1;
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(54, 66);
        default: len = $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        sent++;
      end
      eom_b = 1'($urandom_range(0, 1));
      send_message(len, eom_b);
      sent += len + ((eom_b && len != 0) ? 0 : 1);
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

### sha256_message_hasher_unit.f
+incdir+design
design/sha256u_pkg.sv
design/sha256u_front.sv
design/sha256u_back.sv
design/sha256_message_hasher_unit.sv
test/tb_sha256_message_hasher_unit.sv
